// ===== src/fum_pkg.sv =====
// shared constants, register codes and types for the fsk uart modulator
package fum_pkg;

    // boxcar filter length
    localparam int FILTER_TAPS = 9;
    localparam int POS_W       = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FILTER_TAPS - 1);

    // exact running sum of raw samples, signed
    localparam int SUM_W = 8 + ((FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 0);
    localparam int MAG_W = SUM_W - 1;

    // divide by FILTER_TAPS as multiply by rounded-up reciprocal and shift
    localparam int DIV_SHIFT = 24;
    localparam longint DIV_RECIP_L =
        ((64'sd1 <<< DIV_SHIFT) + FILTER_TAPS - 1) / FILTER_TAPS;
    localparam logic [DIV_SHIFT:0] DIV_RECIP = (DIV_SHIFT + 1)'(DIV_RECIP_L);
    localparam int PROD_W = MAG_W + DIV_SHIFT + 1;

    // configuration register indexes
    localparam logic [2:0] CFG_SPACE_CYCLES  = 3'd0;
    localparam logic [2:0] CFG_MARK_CYCLES   = 3'd1;
    localparam logic [2:0] CFG_SPACE_PERIOD  = 3'd2;
    localparam logic [2:0] CFG_MARK_PERIOD   = 3'd3;
    localparam logic [2:0] CFG_AMPLITUDE     = 3'd4;

    // configuration reset values
    localparam logic [5:0] RST_SPACE_CYCLES = 6'd9;
    localparam logic [5:0] RST_MARK_CYCLES  = 6'd11;
    localparam logic [7:0] RST_SPACE_PERIOD = 8'd11;
    localparam logic [7:0] RST_MARK_PERIOD  = 8'd9;
    localparam logic [6:0] RST_AMPLITUDE    = 7'd96;

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef struct packed {
        logic [5:0] space_cycles;
        logic [5:0] mark_cycles;
        logic [7:0] space_period;
        logic [7:0] mark_period;
        logic [6:0] amplitude;
    } t_cfg;

    typedef struct packed {
        logic signed [7:0] raw;
        logic              accepted;
        logic              busy;
    } t_gen_out;

    typedef struct packed {
        logic                    is_tick;
        logic signed [SUM_W-1:0] sum;
        logic                    accepted;
        logic                    busy;
    } t_stage;

endpackage

// ===== src/fsk_uart_modulator.sv =====
// top level of the fsk modulator with uart framing
//
// one transaction in, one transaction out, one item per clock sustained while the output is not stalled.
// a tick transaction (req_type 0) advances the tone generator by one sample
// and returns the boxcar-filtered sample; a load transaction (req_type 1)
// puts a byte in the holding register if it is free and returns sample 0
// with load_accepted telling whether the byte was taken. holding_busy is
// the holding register state after the transaction. a held byte goes out
// at the next bit boundary as start bit, eight data bits lsb first, stop
// bit; otherwise the line idles on the mark tone. the generator and filter
// state update at the accepting edge into a stage register, and the
// divide by the tap count (reciprocal multiply) feeds the output
// register. the pipeline only stalls when both stages are full and the
// output is stalled. config registers are written through the cfg port
// (always ready) and take effect at once; write them only while the
// block is idle.
module fsk_uart_modulator (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_req_type,
    input  logic [7:0]        i_data_byte,

    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [7:0] o_sample,
    output logic              o_load_accepted,
    output logic              o_holding_busy,

    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    fum_pkg::t_cfg                    r_cfg;
    fum_pkg::t_gen_out                gen;
    logic signed [fum_pkg::SUM_W-1:0] next_sum;
    logic signed [7:0]                avg;

    logic            r_s1_valid;
    fum_pkg::t_stage r_s1;
    logic            r_out_valid;
    logic signed [7:0] r_sample;
    logic            r_load_accepted;
    logic            r_holding_busy;

    logic out_ready;
    logic s1_ready;
    logic accept;
    logic tick_en;

    // pipeline flow control
    assign out_ready = !r_out_valid || !i_out_stall;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign accept    = i_in_valid && s1_ready;
    assign tick_en   = accept && (i_req_type == fum_pkg::REQ_TICK);

    assign o_in_stall  = !s1_ready;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.space_cycles <= fum_pkg::RST_SPACE_CYCLES;
            r_cfg.mark_cycles  <= fum_pkg::RST_MARK_CYCLES;
            r_cfg.space_period <= fum_pkg::RST_SPACE_PERIOD;
            r_cfg.mark_period  <= fum_pkg::RST_MARK_PERIOD;
            r_cfg.amplitude    <= fum_pkg::RST_AMPLITUDE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fum_pkg::CFG_SPACE_CYCLES: r_cfg.space_cycles <= i_cfg_data[5:0];
                fum_pkg::CFG_MARK_CYCLES:  r_cfg.mark_cycles  <= i_cfg_data[5:0];
                fum_pkg::CFG_SPACE_PERIOD: r_cfg.space_period <= i_cfg_data;
                fum_pkg::CFG_MARK_PERIOD:  r_cfg.mark_period  <= i_cfg_data;
                fum_pkg::CFG_AMPLITUDE:    r_cfg.amplitude    <= i_cfg_data[6:0];
                default: begin
                    // writes to unknown indexes are dropped
                end
            endcase
        end
    end

    // framing and tone generation; ticks advance the state, loads fill the holding register
    fum_tone_gen u_tone_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_cfg       (r_cfg),
        .o_gen       (gen)
    );

    // filter ring and running sum, touched by ticks only
    fum_boxcar u_boxcar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (tick_en),
        .i_raw   (gen.raw),
        .o_sum   (next_sum)
    );

    // stage register: exact sum plus load status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.is_tick  <= (i_req_type == fum_pkg::REQ_TICK);
            r_s1.sum      <= next_sum;
            r_s1.accepted <= gen.accepted;
            r_s1.busy     <= gen.busy;
        end
    end

    // average of the ring
    fum_div u_div (
        .i_sum (r_s1.sum),
        .o_avg (avg)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            // a load transaction reports sample zero
            r_sample        <= r_s1.is_tick ? avg : 8'sd0;
            r_load_accepted <= r_s1.accepted;
            r_holding_busy  <= r_s1.busy;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_sample;
    assign o_load_accepted = r_load_accepted;
    assign o_holding_busy  = r_holding_busy;

endmodule

// ===== src/fum_tone_gen.sv =====
// uart framer, holding register and square wave tone generator
module fum_tone_gen (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_req_type,
    input  logic [7:0]        i_data_byte,
    input  fum_pkg::t_cfg     i_cfg,
    output fum_pkg::t_gen_out o_gen
);

    logic [7:0] r_hold_byte, n_hold_byte;
    logic       r_hold_full, n_hold_full;
    logic [9:0] r_frame, n_frame;
    logic [3:0] r_bits_left, n_bits_left;
    logic       r_cur_bit, n_cur_bit;
    logic [5:0] r_period_cnt, n_period_cnt;
    logic [7:0] r_sample_idx, n_sample_idx;

    logic       boundary;
    logic       p_bit;
    logic [9:0] p_frame;
    logic [3:0] p_bits_left;
    logic       p_hold_full;
    logic [7:0] per_len;
    logic [5:0] cyc_len;
    logic [6:0] half;
    logic [8:0] idx_inc;
    logic [6:0] cnt_inc;
    logic [7:0] next_idx;
    logic [5:0] next_cnt;
    logic signed [7:0] amp_s;
    logic signed [7:0] raw;
    logic       accepted;

    assign boundary = (r_period_cnt == 6'd0) && (r_sample_idx == 8'd0);
    assign amp_s    = signed'({1'b0, i_cfg.amplitude});

    // bit selection at a bit boundary
    always_comb begin
        p_bit       = r_cur_bit;
        p_frame     = r_frame;
        p_bits_left = r_bits_left;
        p_hold_full = r_hold_full;
        if (boundary) begin
            priority if (r_bits_left != 4'd0) begin
                p_bit       = r_frame[0];
                p_frame     = {1'b1, r_frame[9:1]};
                p_bits_left = r_bits_left - 4'd1;
            end else if (r_hold_full) begin
                // start bit goes out now, stop bit plus data remain
                p_bit       = 1'b0;
                p_frame     = {2'b11, r_hold_byte};
                p_bits_left = 4'd9;
                p_hold_full = 1'b0;
            end else begin
                p_bit = 1'b1;
            end
        end
    end

    // period shape and counters
    always_comb begin
        per_len = p_bit ? i_cfg.mark_period : i_cfg.space_period;
        cyc_len = p_bit ? i_cfg.mark_cycles : i_cfg.space_cycles;
        if (per_len == 8'd0) per_len = 8'd1;
        if (cyc_len == 6'd0) cyc_len = 6'd1;
        half = per_len[7:1];

        if ({1'b0, r_sample_idx} < {2'b00, half}) begin
            raw = -amp_s;
        end else if ({1'b0, r_sample_idx} < {1'b0, half, 1'b0}) begin
            raw = amp_s;
        end else begin
            raw = 8'sd0;
        end

        idx_inc  = {1'b0, r_sample_idx} + 9'd1;
        cnt_inc  = {1'b0, r_period_cnt} + 7'd1;
        next_idx = idx_inc[7:0];
        next_cnt = r_period_cnt;
        if (idx_inc >= {1'b0, per_len}) begin
            next_idx = 8'd0;
            next_cnt = (cnt_inc >= {1'b0, cyc_len}) ? 6'd0 : cnt_inc[5:0];
        end
    end

    always_comb begin
        n_hold_byte  = r_hold_byte;
        n_hold_full  = r_hold_full;
        n_frame      = r_frame;
        n_bits_left  = r_bits_left;
        n_cur_bit    = r_cur_bit;
        n_period_cnt = r_period_cnt;
        n_sample_idx = r_sample_idx;
        accepted     = 1'b0;
        if (i_en) begin
            if (i_req_type == fum_pkg::REQ_LOAD) begin
                if (!r_hold_full) begin
                    n_hold_byte = i_data_byte;
                    n_hold_full = 1'b1;
                    accepted    = 1'b1;
                end
            end else begin
                n_hold_full  = p_hold_full;
                n_frame      = p_frame;
                n_bits_left  = p_bits_left;
                n_cur_bit    = p_bit;
                n_period_cnt = next_cnt;
                n_sample_idx = next_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_byte  <= 8'd0;
            r_hold_full  <= 1'b0;
            r_frame      <= 10'h3FF;
            r_bits_left  <= 4'd0;
            r_cur_bit    <= 1'b1;
            r_period_cnt <= 6'd0;
            r_sample_idx <= 8'd0;
        end else begin
            r_hold_byte  <= n_hold_byte;
            r_hold_full  <= n_hold_full;
            r_frame      <= n_frame;
            r_bits_left  <= n_bits_left;
            r_cur_bit    <= n_cur_bit;
            r_period_cnt <= n_period_cnt;
            r_sample_idx <= n_sample_idx;
        end
    end

    assign o_gen.raw      = raw;
    assign o_gen.accepted = accepted;
    assign o_gen.busy     = n_hold_full;

endmodule

// ===== src/fum_boxcar.sv =====
// boxcar ring of raw samples with an exact running sum
module fum_boxcar (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic signed [7:0]                i_raw,
    output logic signed [fum_pkg::SUM_W-1:0] o_sum
);

    logic signed [7:0]                r_ring [fum_pkg::FILTER_TAPS];
    logic [fum_pkg::POS_W-1:0]        r_pos, n_pos;
    logic signed [fum_pkg::SUM_W-1:0] r_sum, n_sum;

    always_comb begin
        n_sum = r_sum - fum_pkg::SUM_W'(r_ring[r_pos]) + fum_pkg::SUM_W'(i_raw);
        n_pos = (r_pos == fum_pkg::POS_LAST) ? '0 : r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
            for (int i = 0; i < fum_pkg::FILTER_TAPS; i++) begin
                r_ring[i] <= 8'sd0;
            end
        end else if (i_en) begin
            r_pos         <= n_pos;
            r_sum         <= n_sum;
            r_ring[r_pos] <= i_raw;
        end
    end

    assign o_sum = n_sum;

endmodule

// ===== src/fum_div.sv =====
// signed divide by the tap count, truncating toward zero
module fum_div (
    input  logic signed [fum_pkg::SUM_W-1:0] i_sum,
    output logic signed [7:0]                o_avg
);

    logic                          neg;
    logic [fum_pkg::SUM_W-1:0]     abs_sum;
    logic [fum_pkg::MAG_W-1:0]     mag;
    logic [fum_pkg::PROD_W-1:0]    prod;
    logic [7:0]                    quo;

    always_comb begin
        neg     = i_sum[fum_pkg::SUM_W-1];
        abs_sum = neg ? (~i_sum + 1'b1) : i_sum;
        mag     = abs_sum[fum_pkg::MAG_W-1:0];
        prod    = fum_pkg::PROD_W'(mag) * fum_pkg::PROD_W'(fum_pkg::DIV_RECIP);
        quo     = prod[fum_pkg::DIV_SHIFT +: 8];
        o_avg   = neg ? signed'(8'd0 - quo) : signed'(quo);
    end

endmodule
